// ===== hdl/joint_slew_forward_kinematics_top_assert.svh =====
// Assertion macros for the joint slew forward kinematics block
`ifndef JOINT_SLEW_FORWARD_KINEMATICS_TOP_ASSERT_SVH
`define JOINT_SLEW_FORWARD_KINEMATICS_TOP_ASSERT_SVH

// Property checked on every clock edge outside reset
`define JSFK_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must be followed by an outcome in the next cycle
`define JSFK_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

// ===== hdl/jsfk_pkg.sv =====
// Package: types, constants and helper functions of the forward kinematics block
package jsfk_pkg;

    localparam int FUNC_W  = 3;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 3;
    localparam int LEN_W   = 16;
    localparam int ANG_W   = 20;
    localparam int POS_W   = 20;
    localparam int HEAD_W  = 16;
    localparam int TRIG_W  = 16;
    localparam int SLEW_W  = 16;
    localparam int CX_W    = 34;
    localparam int CZ_W    = 26;
    localparam int PROD_W  = 33;
    localparam int WIDE_W  = 34;
    localparam int POSE_LIMIT = 8;

    localparam logic [SLEW_W-1:0]      SLEW_RESET = 16'd4096;
    localparam logic signed [CX_W-1:0] CORDIC_X0  = 34'sd652032874;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_ADD        = 3'd1,
        FUNC_SET_TARGET = 3'd2,
        FUNC_SET_LENGTH = 3'd3,
        FUNC_REMOVE     = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_TICK_STEP,
        ST_JNT_RD,
        ST_JNT_SLEW,
        ST_CORDIC,
        ST_TRIG,
        ST_MUL,
        ST_OUT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic item_ready;
        logic latch;
        logic add;
        logic rmw_read;
        logic rmw_write;
        logic rem_read;
        logic rem_write;
        logic rem_finish;
        logic tick_start;
        logic joint_read;
        logic joint_slew;
        logic cordic_step;
        logic trig_final;
        logic mul;
        logic load_out;
        logic ptr_next;
    } jsfk_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic        item_valid;
        logic [FUNC_W-1:0] item_func;
        logic        cnt_full;
        logic        idx_ok;
        logic        chain_empty;
        logic        rem_more;
        logic        emit_ok;
        logic        joint_last;
        logic        pose_last;
        logic        cordic_done;
        logic        out_busy;
    } jsfk_sts_t;

    // atan(2^-i) in 2^24 units per turn
    function automatic logic signed [CZ_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate to the signed 20-bit position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 34'sd524287) r = 20'sd524287;
        else if (v < -34'sd524288) r = -20'sd524288;
        else r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/jsfk_if.sv =====
// Channel interfaces: joint items in, poses out, slew rate writes
interface jsfk_item_if;
    import jsfk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [TIME_W-1:0]        time_now;
    logic [IDX_W-1:0]         joint_index;
    logic [LEN_W-1:0]         segment_len;
    logic signed [ANG_W-1:0]  angle_value;
    modport source (output valid, func, time_now, joint_index, segment_len, angle_value,
                    input ready);
    modport sink (input valid, func, time_now, joint_index, segment_len, angle_value,
                  output ready);
endinterface

interface jsfk_pose_if;
    import jsfk_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         pose_index;
    logic signed [POS_W-1:0]  joint_x;
    logic signed [POS_W-1:0]  joint_y;
    logic [HEAD_W-1:0]        heading;
    logic signed [TRIG_W-1:0] cos_heading;
    logic signed [TRIG_W-1:0] sin_heading;
    logic signed [POS_W-1:0]  center_x;
    logic signed [POS_W-1:0]  center_y;
    logic [LEN_W-1:0]         pose_length;
    logic signed [ANG_W-1:0]  pose_angle;
    logic                     last;
    modport source (output valid, pose_index, joint_x, joint_y, heading, cos_heading,
                    sin_heading, center_x, center_y, pose_length, pose_angle, last,
                    input ready);
    modport sink (input valid, pose_index, joint_x, joint_y, heading, cos_heading,
                  sin_heading, center_x, center_y, pose_length, pose_angle, last,
                  output ready);
endinterface

interface jsfk_cfg_if;
    import jsfk_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLEW_W-1:0] slew_rate;
    modport source (output valid, slew_rate, input ready);
    modport sink (input valid, slew_rate, output ready);
endinterface

// ===== hdl/jsfk_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module jsfk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/jsfk_datapath.sv =====
// Datapath: joint table, slew update, iterative CORDIC, pose arithmetic, output register
module jsfk_datapath import jsfk_pkg::*; #(
    parameter int MAX_JOINTS   = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    jsfk_item_if.sink     item,
    jsfk_pose_if.source   pose,
    jsfk_cfg_if.sink      cfg,
    input  jsfk_cmd_t     cmd,
    output jsfk_sts_t     sts
);
    localparam int CW    = $clog2(MAX_JOINTS + 1);
    localparam int AW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int IW    = $clog2(CORDIC_STEPS);
    localparam int ENT_W = LEN_W + 2 * ANG_W;

    // Latched item
    logic [FUNC_W-1:0]        func_reg;
    logic [TIME_W-1:0]        tnow_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [LEN_W-1:0]         len_in_reg;
    logic signed [ANG_W-1:0]  ang_in_reg;

    // Control state
    logic [CW-1:0]            count_reg, count_next;
    logic [TIME_W-1:0]        prev_time_reg;
    logic [SLEW_W-1:0]        slew_reg;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic                     out_valid_reg, out_valid_next;

    // Working registers
    logic [TIME_W-1:0]        step_reg;
    logic                     slew_en_reg;
    logic [HEAD_W-1:0]        head_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [CX_W-1:0]   cx_reg, cy_reg;
    logic signed [CZ_W-1:0]   cz_reg;
    logic                     neg_reg;
    logic [IW-1:0]            iter_reg;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic signed [PROD_W-1:0] prod_s_reg, prod_c_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [ANG_W-1:0]  cur_reg;

    // Output register
    logic [IDX_W-1:0]         o_index_reg;
    logic signed [POS_W-1:0]  o_jx_reg, o_jy_reg, o_cx_reg, o_cy_reg;
    logic [HEAD_W-1:0]        o_head_reg;
    logic signed [TRIG_W-1:0] o_cos_reg, o_sin_reg;
    logic [LEN_W-1:0]         o_len_reg;
    logic signed [ANG_W-1:0]  o_ang_reg;
    logic                     o_last_reg;

    // Table memory: {length, current angle, target angle}
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;
    logic [LEN_W-1:0]        rd_len;
    logic signed [ANG_W-1:0] rd_cur, rd_tgt;

    jsfk_ram #(.WIDTH(ENT_W), .DEPTH(MAX_JOINTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_len = ram_rdata[ENT_W-1 -: LEN_W];
    assign rd_cur = ram_rdata[2*ANG_W-1 -: ANG_W];
    assign rd_tgt = ram_rdata[ANG_W-1:0];

    // Slew of the joint just read
    logic signed [ANG_W:0]   sl_diff;
    logic [ANG_W:0]          sl_mag, sl_move;
    logic signed [ANG_W+1:0] sl_sum;
    logic signed [ANG_W-1:0] sl_cur;

    always_comb
    begin
        sl_diff = {rd_tgt[ANG_W-1], rd_tgt} - {rd_cur[ANG_W-1], rd_cur};
        sl_mag  = sl_diff[ANG_W] ? (ANG_W+1)'(-sl_diff) : sl_diff;
        sl_move = (TIME_W'(sl_mag) < step_reg) ? sl_mag : step_reg[ANG_W:0];
        if (sl_diff[ANG_W])
            sl_sum = {{2{rd_cur[ANG_W-1]}}, rd_cur} - $signed({1'b0, sl_move});
        else
            sl_sum = {{2{rd_cur[ANG_W-1]}}, rd_cur} + $signed({1'b0, sl_move});
        sl_cur = slew_en_reg ? sl_sum[ANG_W-1:0] : rd_cur;
    end

    // Heading and quadrant fold for the CORDIC start
    logic [HEAD_W-1:0]     head_next;
    logic signed [16:0]    fa, fold_a;
    logic                  fold_neg;

    always_comb
    begin
        head_next = head_reg + sl_cur[HEAD_W-1:0];
        fa        = {head_next[HEAD_W-1], head_next};
        fold_neg  = 1'b0;
        fold_a    = fa;
        if (fa > 17'sd16384)
        begin
            fold_a   = fa - 17'sd32768;
            fold_neg = 1'b1;
        end
        else if (fa < -17'sd16384)
        begin
            fold_a   = fa + 17'sd32768;
            fold_neg = 1'b1;
        end
    end

    // One CORDIC rotation
    logic signed [CX_W-1:0] sx, sy;
    logic signed [CZ_W-1:0] ang_step;

    assign sx       = cx_reg >>> iter_reg;
    assign sy       = cy_reg >>> iter_reg;
    assign ang_step = atan_lut(5'(iter_reg));

    // Round to Q1.14, clamp, undo fold
    logic signed [CX_W-1:0]   rx_full, ry_full;
    logic signed [17:0]       rx, ry, cx_cl, cy_cl;
    logic signed [TRIG_W-1:0] cos_next, sin_next;

    always_comb
    begin
        rx_full = (cx_reg + 34'sd32768) >>> 16;
        ry_full = (cy_reg + 34'sd32768) >>> 16;
        rx = rx_full[17:0];
        ry = ry_full[17:0];
        cx_cl = (rx > 18'sd16384) ? 18'sd16384 : ((rx < -18'sd16384) ? -18'sd16384 : rx);
        cy_cl = (ry > 18'sd16384) ? 18'sd16384 : ((ry < -18'sd16384) ? -18'sd16384 : ry);
        cos_next = neg_reg ? TRIG_W'(-cx_cl) : TRIG_W'(cx_cl);
        sin_next = neg_reg ? TRIG_W'(-cy_cl) : TRIG_W'(cy_cl);
    end

    // Offsets and positions of the pose
    logic signed [WIDE_W-1:0] half_s, half_c, full_s, full_c;
    logic signed [WIDE_W-1:0] px_w, py_w;

    always_comb
    begin
        half_s = (WIDE_W'(prod_s_reg) + 34'sd16384) >>> 15;
        half_c = (WIDE_W'(prod_c_reg) + 34'sd16384) >>> 15;
        full_s = (WIDE_W'(prod_s_reg) + 34'sd8192) >>> 14;
        full_c = (WIDE_W'(prod_c_reg) + 34'sd8192) >>> 14;
        px_w   = WIDE_W'(px_reg);
        py_w   = WIDE_W'(py_reg);
    end

    // Tick slew step
    logic [TIME_W-1:0]        delta;
    logic [TIME_W+SLEW_W-1:0] step_prod;

    assign delta     = (tnow_reg >= prev_time_reg) ? (tnow_reg - prev_time_reg) : '0;
    assign step_prod = delta * slew_reg;

    // Table memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(ptr_reg);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(ptr_reg);
        if (cmd.add)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(count_reg);
            ram_wdata = {len_in_reg, ang_in_reg, ang_in_reg};
        end
        else if (cmd.rmw_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_reg);
            if (func_reg == FUNC_SET_TARGET)
                ram_wdata = {rd_len, rd_cur, ang_in_reg};
            else
                ram_wdata = {len_in_reg, rd_cur, rd_tgt};
        end
        else if (cmd.rem_write)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.joint_slew)
        begin
            ram_we    = 1'b1;
            ram_wdata = {rd_len, sl_cur, rd_tgt};
        end
        if (cmd.rmw_read)
            ram_raddr = AW'(idx_reg);
        else if (cmd.rem_read)
            ram_raddr = AW'(ptr_reg + 1'b1);
    end

    // Count, pointer and output valid
    always_comb
    begin
        count_next = count_reg;
        if (cmd.add)
            count_next = count_reg + 1'b1;
        else if (cmd.rem_finish)
            count_next = count_reg - 1'b1;

        ptr_next = ptr_reg;
        if (cmd.latch)
            ptr_next = CW'(item.joint_index);
        else if (cmd.tick_start)
            ptr_next = '0;
        else if (cmd.rem_write || cmd.ptr_next)
            ptr_next = ptr_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (pose.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_time_reg <= '0;
            slew_reg      <= SLEW_RESET;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                slew_reg <= cfg.slew_rate;
            if (cmd.tick_start)
                prev_time_reg <= tnow_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg   <= item.func;
            tnow_reg   <= item.time_now;
            idx_reg    <= item.joint_index;
            len_in_reg <= item.segment_len;
            ang_in_reg <= item.angle_value;
        end
        if (cmd.tick_start)
        begin
            step_reg    <= step_prod[TIME_W+SLEW_W-1:SLEW_W];
            slew_en_reg <= (prev_time_reg != '0);
            head_reg    <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
        end
        if (cmd.joint_slew)
        begin
            head_reg <= head_next;
            cur_reg  <= sl_cur;
            len_reg  <= rd_len;
            neg_reg  <= fold_neg;
            cx_reg   <= CORDIC_X0;
            cy_reg   <= '0;
            cz_reg   <= CZ_W'(fold_a) <<< 8;
            iter_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (!cz_reg[CZ_W-1])
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                cz_reg <= cz_reg - ang_step;
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                cz_reg <= cz_reg + ang_step;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.trig_final)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (cmd.mul)
        begin
            prod_s_reg <= $signed({1'b0, len_reg}) * sin_reg;
            prod_c_reg <= $signed({1'b0, len_reg}) * cos_reg;
        end
        if (cmd.load_out)
        begin
            o_index_reg <= IDX_W'(ptr_reg);
            o_jx_reg    <= px_reg;
            o_jy_reg    <= py_reg;
            o_head_reg  <= head_reg;
            o_cos_reg   <= cos_reg;
            o_sin_reg   <= sin_reg;
            o_cx_reg    <= sat_pos(px_w - half_s);
            o_cy_reg    <= sat_pos(py_w + half_c);
            o_len_reg   <= len_reg;
            o_ang_reg   <= cur_reg;
            o_last_reg  <= sts.pose_last;
            px_reg      <= sat_pos(px_w - full_s);
            py_reg      <= sat_pos(py_w + full_c);
        end
    end

    // Ports
    assign item.ready       = cmd.item_ready;
    assign cfg.ready        = 1'b1;
    assign pose.valid       = out_valid_reg;
    assign pose.pose_index  = o_index_reg;
    assign pose.joint_x     = o_jx_reg;
    assign pose.joint_y     = o_jy_reg;
    assign pose.heading     = o_head_reg;
    assign pose.cos_heading = o_cos_reg;
    assign pose.sin_heading = o_sin_reg;
    assign pose.center_x    = o_cx_reg;
    assign pose.center_y    = o_cy_reg;
    assign pose.pose_length = o_len_reg;
    assign pose.pose_angle  = o_ang_reg;
    assign pose.last        = o_last_reg;

    // Status
    always_comb
    begin
        sts.item_valid  = item.valid;
        sts.item_func   = item.func;
        sts.cnt_full    = (8'(count_reg) >= 8'(MAX_JOINTS));
        sts.idx_ok      = (8'(item.joint_index) < 8'(count_reg));
        sts.chain_empty = (count_reg == '0);
        sts.rem_more    = (8'(ptr_reg) + 8'd1 < 8'(count_reg));
        sts.emit_ok     = (8'(ptr_reg) < 8'(POSE_LIMIT));
        sts.joint_last  = (8'(ptr_reg) + 8'd1 >= 8'(count_reg));
        sts.pose_last   = sts.joint_last || (8'(ptr_reg) + 8'd1 == 8'(POSE_LIMIT));
        sts.cordic_done = (iter_reg == IW'(CORDIC_STEPS - 1));
        sts.out_busy    = out_valid_reg && !pose.ready;
    end
endmodule

// ===== hdl/jsfk_controller.sv =====
// Controller: sequences table edits and the per-joint tick walk
module jsfk_controller import jsfk_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  jsfk_sts_t sts,
    output jsfk_cmd_t cmd
);
    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.item_ready = 1'b1;
                if (sts.item_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (sts.item_func)
                        FUNC_TICK:
                            state_next = ST_TICK_STEP;
                        FUNC_ADD:
                            if (!sts.cnt_full) state_next = ST_ADD;
                        FUNC_SET_TARGET, FUNC_SET_LENGTH:
                            if (sts.idx_ok) state_next = ST_RMW_RD;
                        FUNC_REMOVE:
                            if (sts.idx_ok) state_next = ST_REM_RD;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RMW_RD:
            begin
                cmd.rmw_read = 1'b1;
                state_next   = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                cmd.rmw_write = 1'b1;
                state_next    = ST_IDLE;
            end
            // Shift later joints down one entry at a time
            ST_REM_RD:
            begin
                if (sts.rem_more)
                begin
                    cmd.rem_read = 1'b1;
                    state_next   = ST_REM_WR;
                end
                else
                begin
                    cmd.rem_finish = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_REM_WR:
            begin
                cmd.rem_write = 1'b1;
                state_next    = ST_REM_RD;
            end
            ST_TICK_STEP:
            begin
                cmd.tick_start = 1'b1;
                state_next     = sts.chain_empty ? ST_IDLE : ST_JNT_RD;
            end
            ST_JNT_RD:
            begin
                cmd.joint_read = 1'b1;
                state_next     = ST_JNT_SLEW;
            end
            // Joints past the pose limit are slewed but not emitted
            ST_JNT_SLEW:
            begin
                cmd.joint_slew = 1'b1;
                if (sts.emit_ok)
                    state_next = ST_CORDIC;
                else
                begin
                    cmd.ptr_next = 1'b1;
                    state_next   = sts.joint_last ? ST_IDLE : ST_JNT_RD;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_done)
                    state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                cmd.trig_final = 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.ptr_next = 1'b1;
                    state_next   = sts.joint_last ? ST_IDLE : ST_JNT_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== hdl/joint_slew_forward_kinematics_top.sv =====
// Top level of the joint slew forward kinematics block
//
//   channel  dir  contents
//   item     in   func, time_now, joint_index, segment_len, angle_value
//   pose     out  one pose per joint up to POSE_LIMIT on a tick, last marks the final one
//   cfg      in   slew_rate register write, always ready
//
// Add writes an entry; set target / set length read and rewrite it; remove shifts each later
// joint down by a read and a write. A tick walks the joints through read and slew, and each
// emitted one through the one shared iterative CORDIC rotator, trig, multiply and output.
// rst_n clears the joint count, stored time and output valid and sets the slew rate to
// SLEW_RESET; the table memory is not cleared. A stalled pose holds the walk only when the
// next pose is ready; a new item is taken while the final pose still waits.
module joint_slew_forward_kinematics_top import jsfk_pkg::*; #(
    parameter int MAX_JOINTS   = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    jsfk_item_if.sink   item,
    jsfk_pose_if.source pose,
    jsfk_cfg_if.sink    cfg
);
    jsfk_cmd_t cmd;
    jsfk_sts_t sts;

    jsfk_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    jsfk_datapath #(.MAX_JOINTS(MAX_JOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pose  (pose),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

`include "joint_slew_forward_kinematics_top_assert.svh"

    `JSFK_ASSERT_RST(a_no_overwrite, (cmd.load_out |-> !(pose.valid && !pose.ready)), "pose overwritten while stalled")
    `JSFK_ASSERT_NEXT(a_last_flag, (cmd.load_out && sts.pose_last), (pose.valid && pose.last), "final pose not flagged")
    `JSFK_ASSERT_RST(a_accept_idle, ((item.valid && item.ready) |-> !cmd.load_out), "item taken during pose load")

endmodule
